// File: rtl/wsem_pkg.sv
// Package for the weighted semaphore: operation and status codes, controller
// states, datapath commands and the status struct. No dependencies.
package wsem_pkg;

   localparam int QUEUE_DEPTH_DEF = 8;
   localparam int COUNT_BITS_DEF  = 16;
   localparam int ID_BITS_DEF     = 8;

   localparam int OP_BITS     = 3;
   localparam int AMOUNT_BITS = 16;
   localparam int STATUS_BITS = 3;
   localparam int GRANT_BITS  = 20;

   typedef enum logic [OP_BITS-1:0] {
      OP_TAKE         = 3'd0,
      OP_TRY_TAKE     = 3'd1,
      OP_GRAB_ALL     = 3'd2,
      OP_TRY_GRAB_ALL = 3'd3,
      OP_GIVE         = 3'd4,
      OP_GIVE_ANY     = 3'd5,
      OP_BARRIER      = 3'd6,
      OP_READ         = 3'd7
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      RS_GRANTED = 3'd0,
      RS_QUEUED  = 3'd1,
      RS_BUSY    = 3'd2,
      RS_FULL    = 3'd3,
      RS_RESUMED = 3'd4
   } rsp_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_GIVE,
      S_BAR,
      S_READ
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_SIMPLE,
      CMD_GIVE_INIT,
      CMD_SUM_INIT,
      CMD_GIVE_STEP,
      CMD_BAR_STEP,
      CMD_SUM_STEP,
      CMD_FINISH
   } cmd_type;

   typedef struct packed {
      logic   out_free;
      logic   idx_lt_occ;
      logic   n_zero;
      logic   count_le_amt;
      logic   count_zero;
      op_type op;
   } dp_status_type;

endpackage

// File: rtl/wsem_if.sv
// Channel interfaces for the semaphore: request, response and count register.
// Depends on wsem_pkg for field widths.
interface wsem_req_if #(
   parameter int ID_BITS = wsem_pkg::ID_BITS_DEF
);
   logic                            valid;
   logic                            ready;
   logic [wsem_pkg::OP_BITS-1:0]     operation;
   logic [ID_BITS-1:0]               requester;
   logic [wsem_pkg::AMOUNT_BITS-1:0] amount;
   modport source (output valid, operation, requester, amount, input ready);
   modport sink (input valid, operation, requester, amount, output ready);
endinterface

interface wsem_rsp_if #(
   parameter int ID_BITS = wsem_pkg::ID_BITS_DEF
);
   logic                                  valid;
   logic                                  ready;
   logic [ID_BITS-1:0]                    target;
   logic [wsem_pkg::STATUS_BITS-1:0]      status;
   logic signed [wsem_pkg::GRANT_BITS-1:0] granted;
   logic                                  last;
   modport source (output valid, target, status, granted, last, input ready);
   modport sink (input valid, target, status, granted, last, output ready);
endinterface

interface wsem_csr_if;
   logic                            valid;
   logic                            ready;
   logic [wsem_pkg::AMOUNT_BITS-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// File: rtl/wsem_dp.sv
// Semaphore datapath: count, waiter queue, walk index, accumulator and the
// response register. Driven by commands from wsem_ctrl; uses wsem_pkg.
module wsem_dp #(
   parameter int QUEUE_DEPTH = wsem_pkg::QUEUE_DEPTH_DEF,
   parameter int COUNT_BITS  = wsem_pkg::COUNT_BITS_DEF,
   parameter int ID_BITS     = wsem_pkg::ID_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  wsem_pkg::cmd_type                      cmd,
   input  logic [wsem_pkg::OP_BITS-1:0]           req_operation,
   input  logic [ID_BITS-1:0]                     req_requester,
   input  logic [wsem_pkg::AMOUNT_BITS-1:0]       req_amount,
   input  logic                                   csr_write,
   input  logic [wsem_pkg::AMOUNT_BITS-1:0]       csr_data,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output logic [ID_BITS-1:0]                     rsp_target,
   output logic [wsem_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic signed [wsem_pkg::GRANT_BITS-1:0] rsp_granted,
   output logic                                   rsp_last,
   output wsem_pkg::dp_status_type                st
);
   import wsem_pkg::*;

   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int ACC_W = COUNT_BITS + OCC_W;
   localparam int SW    = 40;
   localparam logic [SW-1:0] CMAX = SW'((64'd1 << COUNT_BITS) - 64'd1);
   localparam logic [OCC_W-1:0] QFULL = OCC_W'(QUEUE_DEPTH);

   logic [COUNT_BITS-1:0] count_ff, count_in, n_ff, n_in, amt_ff, amt_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [OCC_W-1:0]      occ_ff, occ_in, idx_ff, idx_in;
   op_type                op_ff, op_in;
   logic [ID_BITS-1:0]    rq_ff, rq_in;
   logic [ID_BITS-1:0]    id_q_ff [QUEUE_DEPTH];
   logic [ID_BITS-1:0]    id_q_in [QUEUE_DEPTH];
   logic [COUNT_BITS-1:0] need_q_ff [QUEUE_DEPTH];
   logic [COUNT_BITS-1:0] need_q_in [QUEUE_DEPTH];

   logic                  valid_ff, valid_in, last_ff, last_in;
   logic [ID_BITS-1:0]    target_ff, target_in;
   rsp_status_type        status_ff, status_in;
   logic [GRANT_BITS-1:0] granted_ff, granted_in;

   logic [ID_BITS-1:0]    cur_id;
   logic [COUNT_BITS-1:0] cur_need;
   logic [SW-1:0]         give_sum;
   logic                  emit, drop, push, out_free;
   logic [COUNT_BITS-1:0] push_need;

   function automatic logic [COUNT_BITS-1:0] sat_count(input logic [SW-1:0] v);
      return (v > CMAX) ? CMAX[COUNT_BITS-1:0] : v[COUNT_BITS-1:0];
   endfunction

   function automatic logic [GRANT_BITS-1:0] pos_grant(input logic [COUNT_BITS-1:0] v);
      logic [SW-1:0] e;
      e = SW'(v);
      return (e > SW'(524287)) ? 20'h7FFFF : e[GRANT_BITS-1:0];
   endfunction

   function automatic logic [GRANT_BITS-1:0] neg_grant(input logic [ACC_W-1:0] v);
      logic [SW-1:0] e;
      e = SW'(v);
      return (e > SW'(524288)) ? 20'h80000 : 20'(21'd0 - e[GRANT_BITS:0]);
   endfunction

   assign cur_id   = id_q_ff[idx_ff[IDX_W-1:0]];
   assign cur_need = need_q_ff[idx_ff[IDX_W-1:0]];
   assign give_sum = SW'(count_ff) + SW'(amt_ff);
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      count_in   = count_ff;
      n_in       = n_ff;
      amt_in     = amt_ff;
      acc_in     = acc_ff;
      occ_in     = occ_ff;
      idx_in     = idx_ff;
      op_in      = op_ff;
      rq_in      = rq_ff;
      id_q_in    = id_q_ff;
      need_q_in  = need_q_ff;
      emit       = 1'b0;
      drop       = 1'b0;
      push       = 1'b0;
      push_need  = amt_ff;
      target_in  = rq_ff;
      status_in  = RS_GRANTED;
      granted_in = '0;
      last_in    = 1'b1;

      unique case (cmd)
         CMD_LOAD: begin
            op_in  = op_type'(req_operation);
            rq_in  = req_requester;
            amt_in = sat_count(SW'(req_amount));
            idx_in = '0;
         end
         CMD_SIMPLE: begin
            emit = 1'b1;
            unique case (op_ff)
               OP_TAKE, OP_TRY_TAKE: begin
                  if (count_ff >= amt_ff) begin
                     count_in   = count_ff - amt_ff;
                     granted_in = pos_grant(amt_ff);
                  end else if (op_ff == OP_TRY_TAKE) begin
                     status_in = RS_BUSY;
                  end else if (occ_ff < QFULL) begin
                     push      = 1'b1;
                     push_need = amt_ff - count_ff;
                     count_in  = '0;
                     status_in = RS_QUEUED;
                  end else begin
                     status_in = RS_FULL;
                  end
               end
               OP_GRAB_ALL: begin
                  if (count_ff != '0) begin
                     granted_in = pos_grant(count_ff);
                     count_in   = '0;
                  end else if (occ_ff < QFULL) begin
                     push      = 1'b1;
                     push_need = '0;
                     status_in = RS_QUEUED;
                  end else begin
                     status_in = RS_FULL;
                  end
               end
               OP_TRY_GRAB_ALL: begin
                  granted_in = pos_grant(count_ff);
                  count_in   = '0;
               end
               OP_BARRIER: begin
                  // barrier not reached: caller waits with the amount as need
                  if (occ_ff < QFULL) begin
                     push      = 1'b1;
                     count_in  = count_ff - amt_ff;
                     status_in = RS_QUEUED;
                  end else begin
                     status_in = RS_FULL;
                  end
               end
               OP_READ:  granted_in = pos_grant(count_ff);
               default:  granted_in = '0;
            endcase
         end
         CMD_GIVE_INIT: begin
            n_in   = sat_count(give_sum);
            idx_in = '0;
         end
         CMD_SUM_INIT: begin
            acc_in = (op_ff == OP_BARRIER) ? ACC_W'(amt_ff) : '0;
            idx_in = '0;
         end
         CMD_GIVE_STEP: begin
            target_in = cur_id;
            status_in = RS_RESUMED;
            last_in   = 1'b0;
            if (cur_need == '0) begin
               // grab-all waiter gets everything left
               emit       = 1'b1;
               drop       = 1'b1;
               granted_in = pos_grant(n_ff);
               n_in       = '0;
            end else if (cur_need <= n_ff) begin
               emit       = 1'b1;
               drop       = 1'b1;
               granted_in = pos_grant(cur_need);
               n_in       = n_ff - cur_need;
            end else if (op_ff == OP_GIVE) begin
               need_q_in[idx_ff[IDX_W-1:0]] = cur_need - n_ff;
               n_in = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         CMD_BAR_STEP: begin
            emit      = 1'b1;
            target_in = cur_id;
            status_in = RS_RESUMED;
            last_in   = 1'b0;
            acc_in    = acc_ff + ACC_W'(cur_need);
            idx_in    = idx_ff + 1'b1;
         end
         CMD_SUM_STEP: begin
            acc_in = acc_ff + ACC_W'(cur_need);
            idx_in = idx_ff + 1'b1;
         end
         CMD_FINISH: begin
            emit = 1'b1;
            unique case (op_ff)
               OP_BARRIER: begin
                  count_in = sat_count(SW'(acc_ff));
                  occ_in   = '0;
                  idx_in   = '0;
               end
               OP_READ: granted_in = neg_grant(acc_ff);
               default: count_in = n_ff;
            endcase
         end
         default: ;
      endcase

      if (drop) begin
         for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
            if (OCC_W'(j) >= idx_ff) begin
               id_q_in[j]   = id_q_ff[j + 1];
               need_q_in[j] = need_q_ff[j + 1];
            end
         end
         occ_in = occ_ff - 1'b1;
      end
      if (push) begin
         id_q_in[occ_ff[IDX_W-1:0]]   = rq_ff;
         need_q_in[occ_ff[IDX_W-1:0]] = push_need;
         occ_in = occ_ff + 1'b1;
      end
      if (csr_write) begin
         count_in = sat_count(SW'(csr_data));
         occ_in   = '0;
         idx_in   = '0;
      end

      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         occ_ff   <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         occ_ff   <= occ_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      amt_ff    <= amt_in;
      acc_ff    <= acc_in;
      op_ff     <= op_in;
      rq_ff     <= rq_in;
      id_q_ff   <= id_q_in;
      need_q_ff <= need_q_in;
      if (emit) begin
         target_ff  <= target_in;
         status_ff  <= status_in;
         granted_ff <= granted_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_target  = target_ff;
   assign rsp_status  = status_ff;
   assign rsp_granted = granted_ff;
   assign rsp_last    = last_ff;

   assign st.out_free     = out_free;
   assign st.idx_lt_occ   = idx_ff < occ_ff;
   assign st.n_zero       = n_ff == '0;
   assign st.count_le_amt = count_ff <= amt_ff;
   assign st.count_zero   = count_ff == '0;
   assign st.op           = op_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= QFULL) else $error("waiter occupancy beyond queue depth");
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= occ_ff) else $error("walk index beyond occupancy");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free) else $error("response overwritten before taken");
endmodule

// File: rtl/wsem_ctrl.sv
// Semaphore controller: sequences decide, queue walks and the final response
// as commands to wsem_dp. Uses wsem_pkg.
module wsem_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    idle,
   input  wsem_pkg::dp_status_type st,
   output wsem_pkg::cmd_type       cmd
);
   import wsem_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      idle     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            idle = 1'b1;
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (st.out_free) begin
               priority if (st.op == OP_GIVE || st.op == OP_GIVE_ANY) begin
                  cmd      = CMD_GIVE_INIT;
                  state_in = S_GIVE;
               end else if (st.op == OP_BARRIER && st.count_le_amt) begin
                  cmd      = CMD_SUM_INIT;
                  state_in = S_BAR;
               end else if (st.op == OP_READ && st.count_zero) begin
                  cmd      = CMD_SUM_INIT;
                  state_in = S_READ;
               end else begin
                  cmd      = CMD_SIMPLE;
                  state_in = S_IDLE;
               end
            end
         end
         S_GIVE: begin
            if (st.out_free) begin
               if (st.idx_lt_occ && !st.n_zero) begin
                  cmd = CMD_GIVE_STEP;
               end else begin
                  cmd      = CMD_FINISH;
                  state_in = S_IDLE;
               end
            end
         end
         S_BAR: begin
            if (st.out_free) begin
               if (st.idx_lt_occ) begin
                  cmd = CMD_BAR_STEP;
               end else begin
                  cmd      = CMD_FINISH;
                  state_in = S_IDLE;
               end
            end
         end
         S_READ: begin
            // total owed by waiters is summed before the read is answered
            if (st.idx_lt_occ) begin
               cmd = CMD_SUM_STEP;
            end else if (st.out_free) begin
               cmd      = CMD_FINISH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_SIMPLE || cmd == CMD_FINISH || cmd == CMD_BAR_STEP)
      |-> st.out_free) else $error("result issued while response register busy");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd == CMD_LOAD |=> state_ff == S_DECIDE) else $error("load not followed by decide");
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd == CMD_FINISH |=> idle) else $error("finish did not return to idle");
endmodule

// File: rtl/weighted_semaphore_with_wait_queue.sv
// Counting semaphore with an ordered wait queue. A request is taken only
// while the block is idle; each goes through a load step and a decide step,
// and the single-result operations answer in that decide step.
// Give, give_any and a barrier that is reached walk the queue one waiter per
// cycle through the shared queue read port while the response register is
// free, then answer the caller; a read with the count at zero sums waiter
// needs the same way. Every result waits for the response register to be free.
module weighted_semaphore_with_wait_queue #(
   parameter int QUEUE_DEPTH = wsem_pkg::QUEUE_DEPTH_DEF,
   parameter int COUNT_BITS  = wsem_pkg::COUNT_BITS_DEF,
   parameter int ID_BITS     = wsem_pkg::ID_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   wsem_req_if.sink  req,
   wsem_rsp_if.source rsp,
   wsem_csr_if.sink  csr
);
   import wsem_pkg::*;

   cmd_type       cmd;
   dp_status_type st;
   logic          idle;

   assign req.ready = idle;
   assign csr.ready = idle;

   wsem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .idle      (idle),
      .st        (st),
      .cmd       (cmd)
   );

   wsem_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .COUNT_BITS  (COUNT_BITS),
      .ID_BITS     (ID_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_operation (req.operation),
      .req_requester (req.requester),
      .req_amount    (req.amount),
      .csr_write     (csr.valid && idle),
      .csr_data      (csr.data),
      .rsp_ready     (rsp.ready),
      .rsp_valid     (rsp.valid),
      .rsp_target    (rsp.target),
      .rsp_status    (rsp.status),
      .rsp_granted   (rsp.granted),
      .rsp_last      (rsp.last),
      .st            (st)
   );
endmodule
